>>> rtl/pipt_pkg.sv
package pipt_pkg;

  // Polygon table capacity and the index width it implies.
  localparam int unsigned MaxVertices = 64;
  localparam int unsigned VidxW       = $clog2(MaxVertices);
  localparam int unsigned CountW      = 7;
  localparam int unsigned MinVertices = 3;

  localparam int unsigned LonW = 32;
  localparam int unsigned LatW = 31;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic [LonW-1:0] lon;
    logic [LatW-1:0] lat;
  } vertex_t;

  // Issue control for one edge test.
  typedef struct packed {
    logic valid;
    logic last;
  } edge_ctl_t;

  // Result of the edge unit once the closing edge has been folded in.
  typedef struct packed {
    logic done;
    logic parity;
  } edge_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_CLOSE,
    ST_DRAIN
  } pipt_state_e;

endpackage

>>> rtl/pipt_cell.sv
module pipt_cell
  import pipt_pkg::*;
(
  input  logic    clk_i,
  input  logic    shift_i,
  input  logic    wr_en_i,
  input  vertex_t wr_data_i,
  input  vertex_t nb_data_i,
  output vertex_t data_o
);

  vertex_t data_q;

  // A direct write wins; otherwise the ring moves one place toward cell zero.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      data_q <= wr_data_i;
    end else if (shift_i) begin
      data_q <= nb_data_i;
    end
  end

  assign data_o = data_q;

endmodule

>>> rtl/pipt_edge_unit.sv
module pipt_edge_unit
  import pipt_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  edge_ctl_t       ctl_i,
  input  logic [LonW-1:0] px_i,
  input  logic [LatW-1:0] py_i,
  input  vertex_t         vi_i,
  input  vertex_t         vj_i,
  output edge_res_t       res_o
);

  // Stage 1: differences and the straddle test.
  edge_ctl_t          s1_ctl_q;
  logic               s1_strad_q;
  logic               s1_dpos_q;
  logic signed [32:0] s1_a_q;
  logic signed [32:0] s1_b_q;
  logic signed [31:0] s1_c_q;
  logic signed [31:0] s1_dy_q;

  logic               strad_d;
  logic signed [32:0] a_d;
  logic signed [32:0] b_d;
  logic signed [31:0] c_d;
  logic signed [31:0] dy_d;

  always_comb begin
    strad_d = ($signed(vi_i.lat) > $signed(py_i)) != ($signed(vj_i.lat) > $signed(py_i));
    a_d     = $signed({px_i[LonW-1], px_i}) - $signed({vi_i.lon[LonW-1], vi_i.lon});
    b_d     = $signed({vj_i.lon[LonW-1], vj_i.lon}) - $signed({vi_i.lon[LonW-1], vi_i.lon});
    c_d     = $signed({py_i[LatW-1], py_i}) - $signed({vi_i.lat[LatW-1], vi_i.lat});
    dy_d    = $signed({vj_i.lat[LatW-1], vj_i.lat}) - $signed({vi_i.lat[LatW-1], vi_i.lat});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
    end else begin
      s1_ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_strad_q <= strad_d;
    s1_dpos_q  <= !dy_d[31] && (dy_d != 32'sd0);
    s1_a_q     <= a_d;
    s1_b_q     <= b_d;
    s1_c_q     <= c_d;
    s1_dy_q    <= dy_d;
  end

  // Stage 2: the two cross products, one multiplier each.
  edge_ctl_t          s2_ctl_q;
  logic               s2_strad_q;
  logic               s2_dpos_q;
  logic signed [64:0] s2_lhs_q;
  logic signed [64:0] s2_rhs_q;
  logic signed [64:0] lhs_d;
  logic signed [64:0] rhs_d;

  always_comb begin
    lhs_d = s1_a_q * s1_dy_q;
    rhs_d = s1_b_q * s1_c_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctl_q <= '0;
    end else begin
      s2_ctl_q <= s1_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_strad_q <= s1_strad_q;
    s2_dpos_q  <= s1_dpos_q;
    s2_lhs_q   <= lhs_d;
    s2_rhs_q   <= rhs_d;
  end

  // Stage 3: the comparison direction follows the sign of the latitude step,
  // which stands in for the division of the textbook formula.
  logic      crossing;
  logic      parity_q;
  logic      parity_d;
  edge_res_t res_q;
  edge_res_t res_d;

  always_comb begin
    crossing = s2_ctl_q.valid && s2_strad_q &&
               (s2_dpos_q ? (s2_lhs_q < s2_rhs_q) : (s2_lhs_q > s2_rhs_q));
    parity_d = parity_q;
    res_d    = '0;
    if (s2_ctl_q.valid) begin
      parity_d = parity_q ^ crossing;
      if (s2_ctl_q.last) begin
        res_d.done   = 1'b1;
        res_d.parity = parity_q ^ crossing;
        parity_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q <= 1'b0;
      res_q    <= '0;
    end else begin
      parity_q <= parity_d;
      res_q    <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

>>> rtl/point_in_polygon_test_unit.sv
// Channel    Direction  Signals                                   Transfer when
// ---------  ---------  ----------------------------------------  ----------------------
// command    in         start, busy, op_i, vertex_index_i,        start && !busy
//                       lon_i, lat_i
// result     out        done_o, inside_res_o                      done_o (one cycle)
// config     in         vertex_count_we_i, vertex_count_i         vertex_count_we_i
//
// A vertex write leaves busy low.
// A query holds busy while it rotates the vertex ring past the edge unit, tests
// the closing edge, and runs through the edge-unit stages (differences, cross
// products, comparison), the last of which shows the result; the next command
// can go in once busy has fallen. The ring rotation takes up most of a query.
// Reset clears the control path and vertex_count; vertex storage is not cleared.
// The result cannot be stalled by the receiver: done_o is high for exactly one
// cycle per query transfer.
module point_in_polygon_test_unit
  import pipt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               op_i,
  input  logic [VidxW-1:0]   vertex_index_i,
  input  logic [LonW-1:0]    lon_i,
  input  logic [LatW-1:0]    lat_i,
  input  logic               vertex_count_we_i,
  input  logic [CountW-1:0]  vertex_count_i,
  output logic               done_o,
  output logic               inside_res_o
);

  // Configuration register. A count above the table capacity saturates.
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (vertex_count_we_i) begin
      count_q <= vertex_count_i;
    end
  end

  assign n_eff = (count_q > CountW'(MaxVertices)) ? CountW'(MaxVertices) : count_q;

  // Command decode.
  logic    accept;
  logic    wr_cmd;
  logic    query_cmd;
  vertex_t wr_vertex;

  assign accept       = start && !busy;
  assign wr_cmd       = accept && (op_i == OP_WRITE);
  assign query_cmd    = accept && (op_i == OP_QUERY);
  assign wr_vertex.lon = lon_i;
  assign wr_vertex.lat = lat_i;

  // Sequencer.
  pipt_state_e      state_q;
  pipt_state_e      state_d;
  logic [VidxW-1:0] step_q;
  logic [VidxW-1:0] step_d;
  logic             shift;
  edge_ctl_t        ectl;
  edge_res_t        eres;
  vertex_t          head;
  vertex_t          prev_q;
  vertex_t          v0_q;
  vertex_t          last_q;
  vertex_t          vi;
  vertex_t          vj;
  logic             step_in_poly;

  assign step_in_poly = ({1'b0, step_q} < n_eff);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    shift   = 1'b0;
    ectl    = '0;
    vi      = head;
    vj      = prev_q;
    case (state_q)
      ST_IDLE: begin
        if (query_cmd) begin
          state_d = ST_WALK;
          step_d  = '0;
        end
      end
      ST_WALK: begin
        // Cell zero holds vertex step_q; its edge partner is the one before it.
        shift      = 1'b1;
        step_d     = step_q + VidxW'(1);
        ectl.valid = (step_q != '0) && step_in_poly;
        if (step_q == VidxW'(MaxVertices - 1)) begin
          state_d = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        // The ring is home again; test the edge from vertex zero to the last one.
        vi         = v0_q;
        vj         = last_q;
        ectl.valid = 1'b1;
        ectl.last  = 1'b1;
        state_d    = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (eres.done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

  // Query point and vertex captures taken as the ring goes by.
  logic [LonW-1:0] px_q;
  logic [LatW-1:0] py_q;
  logic            enough_q;

  always_ff @(posedge clk_i) begin
    if (query_cmd) begin
      px_q <= lon_i;
      py_q <= lat_i;
    end
    if (state_q == ST_WALK) begin
      prev_q <= head;
      if (step_q == '0) begin
        v0_q <= head;
      end
      if ({1'b0, step_q} == (n_eff - CountW'(1))) begin
        last_q <= head;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enough_q <= 1'b0;
    end else if (query_cmd) begin
      enough_q <= (n_eff >= CountW'(MinVertices));
    end
  end

  // Vertex ring: each cell passes its vertex to the cell below it, and cell
  // zero wraps around to the top, so a full turn of the ring brings every vertex home.
  vertex_t cell_data [MaxVertices];

  for (genvar i = 0; i < MaxVertices; i++) begin : g_cell
    localparam int unsigned Nb = (i + 1) % MaxVertices;
    pipt_cell u_cell (
      .clk_i     (clk_i),
      .shift_i   (shift),
      .wr_en_i   (wr_cmd && (vertex_index_i == VidxW'(i))),
      .wr_data_i (wr_vertex),
      .nb_data_i (cell_data[Nb]),
      .data_o    (cell_data[i])
    );
  end

  assign head = cell_data[0];

  pipt_edge_unit u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ectl),
    .px_i   (px_q),
    .py_i   (py_q),
    .vi_i   (vi),
    .vj_i   (vj),
    .res_o  (eres)
  );

  assign done_o       = eres.done;
  assign inside_res_o = eres.parity && enough_q;

  // A query transfer always makes the unit busy on the next cycle.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_cmd |=> busy)
    else $error("query transfer did not start a walk");

  // A vertex write never starts a walk.
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_cmd |=> !busy)
    else $error("vertex write left the unit busy");

  // A result only appears while draining, and the unit is free right after.
  a_done_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (state_q == ST_DRAIN))
    else $error("result strobe outside the drain phase");

  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("unit still busy after its result");

endmodule
